### rtl/esdt_pkg.sv
// Shared constants and types of the epoch-seconds to civil date-time converter.
package esdt_pkg;

  // Register stages from the input register to the output register.
  localparam int NUM_STAGES = 13;

  // Stage indices, in pipeline order.
  localparam int ST_SUM     = 0;
  localparam int ST_QEST    = 1;
  localparam int ST_REM     = 2;
  localparam int ST_DAYS    = 3;
  localparam int ST_ERA     = 4;
  localparam int ST_DOE     = 5;
  localparam int ST_CENT    = 6;
  localparam int ST_YEAROFS = 7;
  localparam int ST_YOE     = 8;
  localparam int ST_YPARTS  = 9;
  localparam int ST_DOY     = 10;
  localparam int ST_MP      = 11;
  localparam int ST_OUT     = 12;

  // Biased day count (days since March 0000 plus a whole number of eras) and time of day.
  localparam int ZU_W      = 25;
  localparam int TOD_W     = 17;
  localparam int ERA_BIAS  = 64;

  typedef logic [NUM_STAGES-1:0] stage_vec_t;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } hms_t;

endpackage

### rtl/epoch_seconds_to_civil_datetime.sv
// Top level of the epoch-seconds to proleptic Gregorian date and time converter.
//
//   Channel  Direction  Handshake            Beat contents
//   in_      input      in_valid / in_stall  in_seconds_since_epoch (40-bit signed)
//   out_     output     out_valid/out_stall  year, month, day_of_month, hour, minute, second
//   cfg_     input      cfg_valid/cfg_ready  cfg_network_epoch (1 bit)
//
// One beat enters per cycle while the input is not stalled; the depth is set by
// the thirteen register stages of the division chain (86400, era, century, year, month).
// Reset clears the valid bits and selects the 1970 epoch; payload registers are not reset.
// A stall at the output freezes only the stages that have no empty stage at or after them, so
// bubbles close up and the input keeps being taken while any stage is free.
// The configuration channel is always ready; the user must write it only while no beat is in flight (not enforced).
module epoch_seconds_to_civil_datetime import esdt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [39:0] in_seconds_since_epoch,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_year,
  output logic [3:0]         out_month,
  output logic [4:0]         out_day_of_month,
  output logic [4:0]         out_hour,
  output logic [5:0]         out_minute,
  output logic [5:0]         out_second,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_network_epoch
);

  stage_vec_t       load;
  logic             network_epoch_r;
  logic             network_epoch_nxt;
  logic [ZU_W-1:0]  zu;
  logic [TOD_W-1:0] tod;
  hms_t             hms;

  // The epoch select is a plain register; a write takes effect on the next beat.
  assign cfg_ready         = 1'b1;
  assign network_epoch_nxt = (cfg_valid && cfg_ready) ? cfg_network_epoch : network_epoch_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      network_epoch_r <= 1'b0;
    end else begin
      network_epoch_r <= network_epoch_nxt;
    end
  end

  esdt_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .load      (load)
  );

  // Stages 0 to 3: floor division by 86400 into days and seconds of the day.
  esdt_day_split u_day_split (
    .clk           (clk),
    .load          (load),
    .network_epoch (network_epoch_r),
    .seconds       (in_seconds_since_epoch),
    .zu            (zu),
    .tod           (tod)
  );

  // Stages 4 to 12: the date from the day count, in parallel with the clock fields.
  esdt_civil u_civil (
    .clk          (clk),
    .load         (load),
    .zu           (zu),
    .year         (out_year),
    .month        (out_month),
    .day_of_month (out_day_of_month)
  );

  esdt_clock u_clock (
    .clk  (clk),
    .load (load),
    .tod  (tod),
    .hms  (hms)
  );

  assign out_hour   = hms.hour;
  assign out_minute = hms.minute;
  assign out_second = hms.second;

endmodule

### rtl/esdt_pipe_ctrl.sv
// Valid bits and per-stage load enables of the converter pipeline.
module esdt_pipe_ctrl import esdt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       out_stall,
  output logic       in_stall,
  output logic       out_valid,
  output stage_vec_t load
);

  stage_vec_t valid_r;
  stage_vec_t valid_nxt;

  // A stage may load when the output moves on or some stage at or after it is empty.
  always_comb begin
    for (int k = 0; k < NUM_STAGES; k++) begin
      load[k] = !out_stall || ((valid_r >> k) != (stage_vec_t'('1) >> k));
    end
  end

  always_comb begin
    valid_nxt[0] = load[0] ? in_valid : valid_r[0];
    for (int k = 1; k < NUM_STAGES; k++) begin
      valid_nxt[k] = load[k] ? valid_r[k-1] : valid_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign in_stall  = !load[0];
  assign out_valid = valid_r[NUM_STAGES-1];

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> valid_r[0])
    else $error("accepted beat did not enter the first stage");

  a_free_flow: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while the output drains");

  a_bubble_accept: assert property (@(posedge clk) disable iff (!rst_n)
    !(&valid_r) |-> !in_stall)
    else $error("input stalled although the pipeline holds a bubble");

endmodule

### rtl/esdt_day_split.sv
// Splits biased epoch seconds into a day count and a time of day by division by 86400.
module esdt_day_split import esdt_pkg::*; (
  input  logic              clk,
  input  stage_vec_t        load,
  input  logic              network_epoch,
  input  logic [39:0]       seconds,
  output logic [ZU_W-1:0]   zu,
  output logic [TOD_W-1:0]  tod
);

  // 86400 = 128 * 675. The bias keeps the sum positive and is a multiple of 86400.
  localparam logic [40:0] EPOCH_OFS = 41'd946684800;
  localparam logic [40:0] SEC_BIAS  = 41'(64'd675 << 30);
  localparam logic [30:0] M675      = 31'((64'd1 << 40) / 64'd675);
  localparam int          ZU_BIAS   = 719468 + 146097 * ERA_BIAS - (1 << 23);

  logic [40:0] sec_ext;
  logic [40:0] sum_nxt;
  logic [40:0] sum_r;

  logic [54:0] qprod;
  logic [23:0] qest_nxt;
  logic [23:0] qest_r;
  logic [40:0] sum1_r;

  logic [33:0] qmul;
  logic [33:0] rdiff;
  logic [11:0] rem_nxt;
  logic [11:0] rem_r;
  logic [23:0] qest2_r;
  logic [6:0]  low2_r;

  logic [11:0]      rem_c;
  logic [1:0]       corr;
  logic [ZU_W-1:0]  zu_nxt;
  logic [TOD_W-1:0] tod_nxt;
  logic [ZU_W-1:0]  zu_r;
  logic [TOD_W-1:0] tod_r;

  assign sec_ext = {seconds[39], seconds};
  assign sum_nxt = sec_ext + (network_epoch ? EPOCH_OFS : 41'd0) + SEC_BIAS;

  // The quotient estimate from the upper bits is low by at most two.
  assign qprod    = 55'(sum_r[40:17]) * 55'(M675);
  assign qest_nxt = qprod[53:30];

  assign qmul    = 34'(qest_r) * 34'd675;
  assign rdiff   = sum1_r[40:7] - qmul;
  assign rem_nxt = rdiff[11:0];

  always_comb begin
    if (rem_r >= 12'd1350) begin
      corr  = 2'd2;
      rem_c = rem_r - 12'd1350;
    end else if (rem_r >= 12'd675) begin
      corr  = 2'd1;
      rem_c = rem_r - 12'd675;
    end else begin
      corr  = 2'd0;
      rem_c = rem_r;
    end
    zu_nxt  = ZU_W'(qest2_r) + ZU_W'(corr) + ZU_W'(ZU_BIAS);
    tod_nxt = {rem_c[9:0], low2_r};
  end

  always_ff @(posedge clk) begin
    if (load[ST_SUM]) begin
      sum_r <= sum_nxt;
    end
    if (load[ST_QEST]) begin
      qest_r <= qest_nxt;
      sum1_r <= sum_r;
    end
    if (load[ST_REM]) begin
      rem_r   <= rem_nxt;
      qest2_r <= qest_r;
      low2_r  <= sum1_r[6:0];
    end
    if (load[ST_DAYS]) begin
      zu_r  <= zu_nxt;
      tod_r <= tod_nxt;
    end
  end

  assign zu  = zu_r;
  assign tod = tod_r;

endmodule

### rtl/esdt_clock.sv
// Splits the time of day into hour, minute and second, delayed to line up with the date.
module esdt_clock import esdt_pkg::*; (
  input  logic             clk,
  input  stage_vec_t       load,
  input  logic [TOD_W-1:0] tod,
  output hms_t             hms
);

  localparam logic [17:0] MH = 18'(((64'd1 << 29) + 64'd3599) / 64'd3600);
  localparam logic [12:0] MM = 13'(((64'd1 << 18) + 64'd59) / 64'd60);

  logic [34:0]      hprod;
  logic [4:0]       hh_nxt;
  logic [4:0]       hh4_r;
  logic [TOD_W-1:0] tod4_r;

  logic [TOD_W-1:0] hsub;
  logic [11:0]      rem_nxt;
  logic [11:0]      rem5_r;
  logic [4:0]       hh5_r;

  logic [24:0] mprod;
  logic [5:0]  mm_nxt;
  logic [5:0]  mm6_r;
  logic [11:0] rem6_r;
  logic [4:0]  hh6_r;

  logic [11:0] mmul;
  hms_t        hms_nxt;
  hms_t        hms7_r;
  hms_t        dly_r [ST_YEAROFS+1:ST_OUT];

  assign hprod   = 35'(tod) * 35'(MH);
  assign hh_nxt  = hprod[33:29];

  assign hsub    = tod4_r - TOD_W'(hh4_r) * TOD_W'(3600);
  assign rem_nxt = hsub[11:0];

  assign mprod   = 25'(rem5_r) * 25'(MM);
  assign mm_nxt  = mprod[23:18];

  assign mmul            = 12'(mm6_r) * 12'd60;
  assign hms_nxt.hour    = hh6_r;
  assign hms_nxt.minute  = mm6_r;
  assign hms_nxt.second  = 6'(rem6_r - mmul);

  always_ff @(posedge clk) begin
    if (load[ST_ERA]) begin
      hh4_r  <= hh_nxt;
      tod4_r <= tod;
    end
    if (load[ST_DOE]) begin
      rem5_r <= rem_nxt;
      hh5_r  <= hh4_r;
    end
    if (load[ST_CENT]) begin
      mm6_r  <= mm_nxt;
      rem6_r <= rem5_r;
      hh6_r  <= hh5_r;
    end
    if (load[ST_YEAROFS]) begin
      hms7_r <= hms_nxt;
    end
  end

  for (genvar k = ST_YEAROFS + 1; k <= ST_OUT; k++) begin : g_dly
    if (k == ST_YEAROFS + 1) begin : g_first
      always_ff @(posedge clk) begin
        if (load[k]) begin
          dly_r[k] <= hms7_r;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (load[k]) begin
          dly_r[k] <= dly_r[k-1];
        end
      end
    end
  end

  assign hms = dly_r[ST_OUT];

endmodule

### rtl/esdt_civil.sv
// Converts a biased day count into year, month and day through 400-year eras.
module esdt_civil import esdt_pkg::*; (
  input  logic              clk,
  input  stage_vec_t        load,
  input  logic [ZU_W-1:0]   zu,
  output logic signed [15:0] year,
  output logic [3:0]        month,
  output logic [4:0]        day_of_month
);

  localparam logic [25:0] MERA   = 26'(((64'd1 << 43) + 64'd146096) / 64'd146097);
  localparam logic [17:0] M1460  = 18'(((64'd1 << 28) + 64'd1459) / 64'd1460);
  localparam logic [17:0] M36524 = 18'(((64'd1 << 33) + 64'd36523) / 64'd36524);
  localparam logic [17:0] M365   = 18'(((64'd1 << 26) + 64'd364) / 64'd365);
  localparam logic [9:0]  M100   = 10'(((64'd1 << 16) + 64'd99) / 64'd100);
  localparam logic [11:0] M153   = 12'(((64'd1 << 19) + 64'd152) / 64'd153);

  // First day of each month within a year that starts on March 1.
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] s;
    case (mp)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

  function automatic logic [3:0] month_num(input logic [3:0] mp);
    logic [3:0] m;
    if (mp < 4'd10) begin
      m = mp + 4'd3;
    end else begin
      m = mp - 4'd9;
    end
    return m;
  endfunction

  logic [50:0]     era_prod;
  logic [6:0]      era_nxt;
  logic [6:0]      era4_r;
  logic [ZU_W-1:0] zu4_r;

  logic [24:0] era_mul;
  logic [24:0] doe_diff;
  logic [17:0] doe_nxt;
  logic [17:0] doe5_r;
  logic [6:0]  era5_r;

  logic [35:0] p1460;
  logic [35:0] p36524;
  logic [7:0]  c1460_r;
  logic [2:0]  c36524_r;
  logic        full_r;
  logic [17:0] doe6_r;
  logic [6:0]  era6_r;

  logic [17:0] t_nxt;
  logic [17:0] t7_r;
  logic [17:0] doe7_r;
  logic [6:0]  era7_r;

  logic [35:0] p365;
  logic [8:0]  yoe8_r;
  logic [17:0] doe8_r;
  logic [6:0]  era8_r;

  logic [18:0] p100;
  logic [17:0] y365_r;
  logic [2:0]  c100_r;
  logic [8:0]  yoe9_r;
  logic [17:0] doe9_r;
  logic [6:0]  era9_r;

  logic [17:0] ysum;
  logic [17:0] doy_diff;
  logic [8:0]  doy10_r;
  logic [8:0]  yoe10_r;
  logic [6:0]  era10_r;

  logic [10:0] mpn;
  logic [22:0] p153;
  logic [3:0]  mp11_r;
  logic [8:0]  doy11_r;
  logic [8:0]  yoe11_r;
  logic [6:0]  era11_r;

  logic signed [8:0]  era_s;
  logic signed [16:0] year_full;
  logic [8:0]         day_diff;
  logic signed [15:0] year_r;
  logic [3:0]         month_r;
  logic [4:0]         day_r;

  assign era_prod = 51'(zu) * 51'(MERA);
  assign era_nxt  = era_prod[49:43];

  assign era_mul  = 25'(era4_r) * 25'd146097;
  assign doe_diff = zu4_r - era_mul;
  assign doe_nxt  = doe_diff[17:0];

  assign p1460  = 36'(doe5_r) * 36'(M1460);
  assign p36524 = 36'(doe5_r) * 36'(M36524);

  assign t_nxt = doe6_r - 18'(c1460_r) + 18'(c36524_r) - 18'(full_r);

  assign p365 = 36'(t7_r) * 36'(M365);

  assign p100 = 19'(yoe8_r) * 19'(M100);

  assign ysum     = y365_r + 18'(yoe9_r[8:2]) - 18'(c100_r);
  assign doy_diff = doe9_r - ysum;

  assign mpn  = 11'(doy10_r) * 11'd5 + 11'd2;
  assign p153 = 23'(mpn) * 23'(M153);

  // January and February belong to the following civil year.
  assign era_s     = $signed({2'b00, era11_r}) - 9'sd64;
  assign year_full = 17'(era_s) * 17'sd400 + $signed({8'd0, yoe11_r})
                   + $signed({16'd0, (mp11_r >= 4'd10)});
  assign day_diff  = doy11_r - month_start(mp11_r) + 9'd1;

  always_ff @(posedge clk) begin
    if (load[ST_ERA]) begin
      era4_r <= era_nxt;
      zu4_r  <= zu;
    end
    if (load[ST_DOE]) begin
      doe5_r <= doe_nxt;
      era5_r <= era4_r;
    end
    if (load[ST_CENT]) begin
      c1460_r  <= p1460[35:28];
      c36524_r <= p36524[35:33];
      full_r   <= (doe5_r == 18'd146096);
      doe6_r   <= doe5_r;
      era6_r   <= era5_r;
    end
    if (load[ST_YEAROFS]) begin
      t7_r   <= t_nxt;
      doe7_r <= doe6_r;
      era7_r <= era6_r;
    end
    if (load[ST_YOE]) begin
      yoe8_r <= p365[34:26];
      doe8_r <= doe7_r;
      era8_r <= era7_r;
    end
    if (load[ST_YPARTS]) begin
      y365_r <= 18'(yoe8_r) * 18'd365;
      c100_r <= p100[18:16];
      yoe9_r <= yoe8_r;
      doe9_r <= doe8_r;
      era9_r <= era8_r;
    end
    if (load[ST_DOY]) begin
      doy10_r <= doy_diff[8:0];
      yoe10_r <= yoe9_r;
      era10_r <= era9_r;
    end
    if (load[ST_MP]) begin
      mp11_r  <= p153[22:19];
      doy11_r <= doy10_r;
      yoe11_r <= yoe10_r;
      era11_r <= era10_r;
    end
    if (load[ST_OUT]) begin
      year_r  <= year_full[15:0];
      month_r <= month_num(mp11_r);
      day_r   <= day_diff[4:0];
    end
  end

  assign year         = year_r;
  assign month        = month_r;
  assign day_of_month = day_r;

endmodule
